FILE: hw/rtl/bit_matrix_column_transpose_top_defines.svh
// ----------------------------------------------------------------------------
// Bit matrix column transpose assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BIT_MATRIX_COLUMN_TRANSPOSE_TOP_DEFINES_SVH
`define BIT_MATRIX_COLUMN_TRANSPOSE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bmct_pkg.sv
// ----------------------------------------------------------------------------
// Bit matrix column transpose package
// Shared widths, defaults and the per-cell control bundle.
// ----------------------------------------------------------------------------
package bmct_pkg;

  localparam int COL_W         = 32;   // bits held per column word
  localparam int NUM_COLS      = 32;   // columns per word index
  localparam int ROW_LIMIT     = 32;   // largest usable row count
  localparam int ROW_CNT_W     = 5;
  localparam int COL_IDX_W     = 5;
  localparam int IDX_W         = 17;
  localparam int CFG_W         = 6;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 56;
  localparam int MAX_WORDS_DEF = 4096;

  // Control shared by every cell of the chain in one cycle.
  typedef struct packed {
    logic acc_en;    // a row word is taken this cycle
    logic complete;  // that row closes the group: hand over and clear
    logic shift;     // the unload chain advances by one column
  } cell_ctl_t;

endpackage

FILE: hw/rtl/bit_matrix_column_transpose_top.sv
// ----------------------------------------------------------------------------
// Bit matrix column transpose top level
// Latency: the first column appears the cycle after the transaction that
//   carries the last row of a word index; the rest follow one per cycle while out_tready is high.
// Throughput: one row word per cycle, except that the row closing a group
//   waits for the 32-slot unload chain to be free; the chain drains one
//   column a cycle while out_tready is high.
// Reset: synchronous active-low rst_n clears the column accumulators and counters and
//   sets rows_in_use to 32; the block is ready the cycle after release.
// ----------------------------------------------------------------------------
`include "bit_matrix_column_transpose_top_defines.svh"

module bit_matrix_column_transpose_top
  import bmct_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEF
)(
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write channel: rows_in_use.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  // Row words.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] row_word
  // Column words.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] column_bits, [48:32] column_index,
                                             // [55:49] zero
  output logic                   out_tlast   // last_column
);

  localparam int WC_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int FULL_W = WC_W + COL_IDX_W;
  localparam int CNT_W  = $clog2(NUM_COLS + 1);

  // The configuration register is always writable; it takes effect at once,
  // including in the middle of a group.
  logic [CFG_W-1:0]     rows_r;
  logic [CFG_W-1:0]     rows_eff;
  logic [ROW_CNT_W-1:0] row_cnt_r;
  logic [ROW_CNT_W-1:0] row_cnt_nxt;
  logic [WC_W-1:0]      wc_r;
  logic [WC_W-1:0]      wc_nxt;
  logic [WC_W-1:0]      out_wc_r;
  logic [WC_W-1:0]      out_wc_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [COL_IDX_W-1:0] col_r;
  logic [COL_IDX_W-1:0] col_nxt;
  logic                 last_row;
  logic                 chain_free;
  logic                 in_fire;
  logic                 out_fire;
  logic [FULL_W-1:0]    idx_full;
  cell_ctl_t            ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(ROW_LIMIT);
    end else if (cfg_valid && cfg_ready) begin
      rows_r <= cfg_data;
    end
  end

  // A row count of zero behaves as one row, anything above the limit as the limit.
  always_comb begin
    rows_eff = rows_r;
    if (rows_r == '0) begin
      rows_eff = CFG_W'(1);
    end else if (rows_r > CFG_W'(ROW_LIMIT)) begin
      rows_eff = CFG_W'(ROW_LIMIT);
    end
  end

  // The group closes when the rows received, counting this one, reach the
  // row count. This depends only on control state, never on the data.
  assign last_row = ({1'b0, row_cnt_r} + CFG_W'(1)) >= rows_eff;

  assign out_fire = out_tvalid && out_tready;

  // The unload chain can take a new group when it is empty, or when its last
  // column leaves in this same cycle. Non-final rows are never held back.
  assign chain_free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_fire);
  assign in_tready  = !last_row || chain_free;
  assign in_fire    = in_tvalid && in_tready;

  assign ctl.acc_en   = in_fire;
  assign ctl.complete = last_row;
  assign ctl.shift    = out_fire;

  always_comb begin
    row_cnt_nxt = row_cnt_r;
    wc_nxt      = wc_r;
    out_wc_nxt  = out_wc_r;
    cnt_nxt     = cnt_r;
    col_nxt     = col_r;
    if (out_fire) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      col_nxt = col_r + COL_IDX_W'(1);
    end
    if (in_fire) begin
      if (last_row) begin
        row_cnt_nxt = '0;
        out_wc_nxt  = wc_r;
        wc_nxt      = (wc_r == WC_W'(MAX_WORDS - 1)) ? '0 : wc_r + WC_W'(1);
        cnt_nxt     = CNT_W'(NUM_COLS);
        col_nxt     = '0;
      end else begin
        row_cnt_nxt = row_cnt_r + ROW_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      wc_r      <= '0;
      out_wc_r  <= '0;
      cnt_r     <= '0;
      col_r     <= '0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      wc_r      <= wc_nxt;
      out_wc_r  <= out_wc_nxt;
      cnt_r     <= cnt_nxt;
      col_r     <= col_nxt;
    end
  end

  // Chain of cells: cell b accumulates column b, and on unload hands its word
  // toward cell 0, which faces the output. The far end shifts in zeros.
  logic [COL_W-1:0] chain [NUM_COLS+1];

  assign chain[NUM_COLS] = '0;

  for (genvar b = 0; b < NUM_COLS; b++) begin : g_cell
    bmct_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .row_bit   (in_tdata[b]),
      .shift_in  (chain[b+1]),
      .shift_out (chain[b])
    );
  end

  // Column index is word index times 32 plus the column, kept to 17 bits.
  assign idx_full   = {out_wc_r, col_r};
  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = (cnt_r == CNT_W'(1));
  assign out_tdata  = {(OUT_TDATA_W - COL_W - IDX_W)'(0), IDX_W'(idx_full), chain[0]};

  // Closing a group always loads a full set of columns into the chain.
  `BMCT_ASSERT_NEXT(a_group_loads_chain, in_fire && last_row, cnt_r == CNT_W'(NUM_COLS), "group did not load a full column set")
  // Columns of one group leave without a gap in validity.
  `BMCT_ASSERT_NEXT(a_run_continues, out_fire && !out_tlast, out_tvalid, "column run broke before its last column")
  // Within a run the column number steps by one per transaction.
  `BMCT_ASSERT_NEXT(a_col_steps, out_fire && !out_tlast && !(in_fire && last_row), col_r == $past(col_r) + COL_IDX_W'(1), "column index did not advance")
  // The last column is always column 31 of its word index.
  `BMCT_ASSERT_SAME(a_last_is_top, out_tvalid && out_tlast, col_r == COL_IDX_W'(NUM_COLS - 1), "last column flag on wrong column")

endmodule

FILE: hw/rtl/bmct_cell.sv
// ----------------------------------------------------------------------------
// Bit matrix column transpose cell
// Accumulates one column and holds one slot of the unload chain.
// ----------------------------------------------------------------------------
module bmct_cell
  import bmct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic             row_bit,
  input  logic [COL_W-1:0] shift_in,
  output logic [COL_W-1:0] shift_out
);

  logic [COL_W-1:0] acc_r;
  logic [COL_W-1:0] acc_nxt;
  logic [COL_W-1:0] acc_shift;
  logic [COL_W-1:0] unload_r;
  logic [COL_W-1:0] unload_nxt;

  assign acc_shift = {acc_r[COL_W-2:0], row_bit};

  always_comb begin
    acc_nxt    = acc_r;
    unload_nxt = unload_r;
    if (ctl.acc_en) begin
      acc_nxt = ctl.complete ? '0 : acc_shift;
    end
    if (ctl.acc_en && ctl.complete) begin
      unload_nxt = acc_shift;
    end else if (ctl.shift) begin
      unload_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Payload only: validity is tracked by the column count at the top level.
  always_ff @(posedge clk) begin
    unload_r <= unload_nxt;
  end

  assign shift_out = unload_r;

endmodule
